// File: rtl/bsr_pkg.sv
`default_nettype none

package bsr_pkg;

	localparam int BSR_NUM_SQUARES = 64;
	localparam int BSR_NUM_IDS     = 32;
	localparam int BSR_ID_W        = 6;
	localparam int BSR_POS_W       = 11;

endpackage

`default_nettype wire

// File: rtl/bsr_store.sv
`default_nettype none

// 64-entry id store: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as empty after reset.
module bsr_store
	import bsr_pkg::*;
#(
	parameter int DEPTH = BSR_NUM_SQUARES,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire logic [AW-1:0]       wr_addr,
	input  wire logic [BSR_ID_W-1:0] wr_data,
	input  wire logic                rd_en,
	input  wire logic [AW-1:0]       rd_addr,
	output logic      [BSR_ID_W-1:0] rd_data
);

	logic [BSR_ID_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]    valid_q;
	logic [BSR_ID_W-1:0] mem_rd_q;
	logic                rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? mem_rd_q : '0;

endmodule

`default_nettype wire

// File: rtl/board_sensor_serial_readout.sv
`default_nettype none

// Channel   Dir  Signals                         Contents
// s_*       in   s_tvalid/s_tready/s_tdata/tuser line level or sensor update
// m_*       out  m_tvalid/m_tready/m_tdata/tuser serial bit and LED write
//
// One item in flight at a time; every item gives exactly one result.
// Line and sensor items go straight to the result; falling edge of B first reads the square store.
// Scan copy on falling edge of A: one square a cycle through the
//   sensor store read port, then one square store read for the output bit.
// Reset clears both stores at once through per-entry valid bits.
// A result waiting on m_tready holds the sequencer; s_tready is high only
//   while idle.
module board_sensor_serial_readout
	import bsr_pkg::*;
#(
	parameter int NUM_SQUARES = BSR_NUM_SQUARES,
	parameter int NUM_IDS     = BSR_NUM_IDS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // level[0], sensor_col[3:1], sensor_row[6:4], piece[12:7]
	input  wire logic [1:0]  s_tuser,  // kind[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // data_out[0], led_index[6:1], led_value[7]
	output logic             m_tuser   // led_write[0]
);

	localparam int AW    = $clog2(NUM_SQUARES);
	localparam int HALF  = AW / 2;
	localparam int WANTW = BSR_POS_W - AW;
	localparam logic [BSR_ID_W-1:0] MAX_ID = BSR_ID_W'(NUM_IDS);

	typedef enum logic [1:0] {
		KIND_LINE_A = 2'd0,
		KIND_LINE_B = 2'd1,
		KIND_SENSOR = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COPY,
		ST_DRAIN,
		ST_RD,
		ST_CMP,
		ST_RES
	} state_t;

	state_t                state_q;
	logic                  line_a_q, line_b_q, armed_q, out_bit_q;
	logic [BSR_POS_W-1:0]  pos_q;
	logic [AW-1:0]         cnt_q;
	logic                  led_wr_q, led_val_q;
	logic [AW-1:0]         led_idx_q;
	logic                  cp_wr_s1;
	logic [AW-1:0]         cp_idx_s1;
	logic                  m_tvalid_q;
	logic [7:0]            m_tdata_q;
	logic                  m_tuser_q;

	// input fields
	kind_t                 in_kind;
	logic                  in_level;
	logic [2:0]            in_col, in_row;
	logic [BSR_ID_W-1:0]   in_piece;
	logic                  accept;
	logic                  led_hit;

	logic [AW-1:0]         sens_rd_addr;
	logic [BSR_ID_W-1:0]   sens_rd_data;
	logic [BSR_ID_W-1:0]   sq_rd_data;
	logic                  match;

	assign in_kind  = kind_t'(s_tuser);
	assign in_level = s_tdata[0];
	assign in_col   = s_tdata[3:1];
	assign in_row   = s_tdata[6:4];
	assign in_piece = s_tdata[12:7];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// falling edge of A with no scan armed writes an LED
	assign led_hit = (in_kind == KIND_LINE_A) && !in_level && line_a_q && !armed_q;

	// square i takes sensor row 7-(i&7) and column (i>>3)^7
	assign sens_rd_addr = {~cnt_q[HALF-1:0], ~cnt_q[AW-1:HALF]};

	bsr_store #(.DEPTH(NUM_SQUARES)) u_sensor (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && in_kind == KIND_SENSOR),
		.wr_addr ({in_row, in_col}),
		.wr_data (in_piece),
		.rd_en   (state_q == ST_COPY),
		.rd_addr (sens_rd_addr),
		.rd_data (sens_rd_data)
	);

	bsr_store #(.DEPTH(NUM_SQUARES)) u_square (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cp_wr_s1),
		.wr_addr (cp_idx_s1),
		.wr_data (sens_rd_data),
		.rd_en   (state_q == ST_RD),
		.rd_addr (pos_q[AW-1:0]),
		.rd_data (sq_rd_data)
	);

	// serial bit: id nonzero, in range, and id-1 equals position bits above the square
	assign match = (sq_rd_data != '0) && (sq_rd_data <= MAX_ID)
		&& ((sq_rd_data - BSR_ID_W'(1)) == BSR_ID_W'(pos_q[BSR_POS_W-1:AW]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			line_a_q   <= 1'b0;
			line_b_q   <= 1'b0;
			armed_q    <= 1'b0;
			out_bit_q  <= 1'b0;
			pos_q      <= '0;
			cnt_q      <= '0;
			led_wr_q   <= 1'b0;
			led_val_q  <= 1'b0;
			led_idx_q  <= '0;
			cp_wr_s1   <= 1'b0;
			cp_idx_s1  <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
		end else begin
			cp_wr_s1  <= (state_q == ST_COPY);
			cp_idx_s1 <= cnt_q;
			// a result leaving while the next one loads is handled in ST_RES
			if (m_tvalid_q && m_tready && (state_q != ST_RES)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						led_wr_q  <= led_hit;
						led_idx_q <= led_hit ? pos_q[AW-1:0] : '0;
						led_val_q <= led_hit && line_b_q;
						unique case (in_kind)
							KIND_LINE_A: begin
								line_a_q <= in_level;
								if (!in_level && line_a_q && armed_q) begin
									cnt_q   <= '0;
									state_q <= ST_COPY;
								end else begin
									state_q <= ST_RES;
								end
							end
							KIND_LINE_B: begin
								line_b_q <= in_level;
								if (!in_level && line_b_q) begin
									pos_q <= pos_q + BSR_POS_W'(1);
									if (line_a_q) begin
										armed_q <= 1'b1;
									end
									state_q <= ST_RD;
								end else begin
									state_q <= ST_RES;
								end
							end
							KIND_SENSOR, KIND_NONE: begin
								state_q <= ST_RES;
							end
						endcase
					end
				end
				ST_COPY: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == AW'(NUM_SQUARES - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// last square lands this cycle
					armed_q <= 1'b0;
					pos_q   <= '0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					out_bit_q <= match;
					state_q   <= ST_RES;
				end
				ST_RES: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {led_val_q, led_idx_q, out_bit_q};
						m_tuser_q  <= led_wr_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	logic unused_tdata;
	assign unused_tdata = ^{s_tdata[15:13], WANTW[0]};

endmodule

`default_nettype wire

// File: rtl/bsr_checker.sv
`default_nettype none

module bsr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [15:0] s_tdata,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata,
	input wire logic        m_tuser
);

	// no LED write: LED fields read as zero
	a_led_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[7:1] == 7'd0))
		else $error("LED fields set without LED write");

	// one transaction in flight: input closes after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken while one is in flight");

	// no result without an item: a fresh result follows a busy period
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !$past(m_tvalid)) |-> !$past(s_tready))
		else $error("result appeared with no item in flight");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind board_sensor_serial_readout bsr_checker u_bsr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// File: bench/bsr_readout_monitor.sv
`timescale 1ns / 1ps

package bsr_tb_pkg;

	typedef enum logic [1:0] {
		KIND_LINE_A = 2'd0,
		KIND_LINE_B = 2'd1,
		KIND_SENSOR = 2'd2,
		KIND_UNUSED = 2'd3
	} item_kind_e;

	typedef struct packed {
		logic       data_out;
		logic       led_write;
		logic [5:0] led_index;
		logic       led_value;
	} readout_t;

endpackage

module bsr_readout_monitor
	import bsr_pkg::*;
	import bsr_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // level[0], sensor_col[3:1], sensor_row[6:4], piece[12:7]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // data_out[0], led_index[6:1], led_value[7]
	input  logic        m_tuser,   // led_write[0]
	output int          mismatches,
	output int          outstanding
);

	// shadow copy of the board interface
	logic                 line_a;
	logic                 line_b;
	logic                 armed;
	logic                 out_bit;
	logic [BSR_POS_W-1:0] position;
	logic [BSR_ID_W-1:0]  square_ids [BSR_NUM_SQUARES];
	logic [BSR_ID_W-1:0]  sensor_ids [BSR_NUM_SQUARES];

	readout_t expected_readouts [$];
	readout_t want;
	readout_t got;
	int       fail_total = 0;

	assign mismatches = fail_total;

	function automatic logic id_at_position(input logic [BSR_ID_W-1:0] id,
			input logic [BSR_POS_W-1:0] pos);
		int wanted;
		wanted = int'(pos[BSR_POS_W-1:6]);
		return (id != 0) && (int'(id) <= BSR_NUM_IDS) && ((int'(id) - 1) == wanted);
	endfunction

	task automatic board_step(input item_kind_e kind, input logic level,
			input logic [2:0] col, input logic [2:0] row,
			input logic [BSR_ID_W-1:0] piece, output readout_t r);
		int c;
		int rw;
		r = '0;
		case (kind)
			KIND_LINE_A: begin
				if (!level && line_a) begin
					if (armed) begin
						// square i <- sensor column (i>>3)^7, row 7-(i&7)
						for (int i = 0; i < BSR_NUM_SQUARES; i++) begin
							c  = ((i >> 3) ^ 7) & 7;
							rw = 7 - (i & 7);
							square_ids[i] = sensor_ids[(rw * 8 + c) & 63];
						end
						armed    = 1'b0;
						position = '0;
						out_bit  = id_at_position(square_ids[0], position);
					end else begin
						r.led_write = 1'b1;
						r.led_index = position[5:0];
						r.led_value = line_b;
					end
				end
				line_a = level;
			end
			KIND_LINE_B: begin
				if (!level && line_b) begin
					position = position + 1'b1;
					if (line_a)
						armed = 1'b1;
					out_bit = id_at_position(square_ids[position[5:0]], position);
				end
				line_b = level;
			end
			KIND_SENSOR: begin
				sensor_ids[{row, col}] = piece;
			end
			default: begin
			end
		endcase
		r.data_out = out_bit;
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			fail_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_a   = 1'b0;
			line_b   = 1'b0;
			armed    = 1'b0;
			out_bit  = 1'b0;
			position = '0;
			for (int i = 0; i < BSR_NUM_SQUARES; i++) begin
				square_ids[i] = '0;
				sensor_ids[i] = '0;
			end
			expected_readouts.delete();
			outstanding <= 0;
		end else begin
			// result side first: it always belongs to an older transaction
			if (m_tvalid && m_tready) begin
				got.data_out  = m_tdata[0];
				got.led_write = m_tuser;
				got.led_index = m_tdata[6:1];
				got.led_value = m_tdata[7];
				if (expected_readouts.size() == 0) begin
					$display("%0t: unexpected readout, expected none, actual %h",
						$time, got);
					fail_total++;
				end else begin
					want = expected_readouts.pop_front();
					check_field("data_out", want.data_out, got.data_out);
					check_field("led_write", want.led_write, got.led_write);
					check_field("led_index", want.led_index, got.led_index);
					check_field("led_value", want.led_value, got.led_value);
				end
			end
			if (s_tvalid && s_tready) begin
				board_step(item_kind_e'(s_tuser), s_tdata[0], s_tdata[3:1], s_tdata[6:4],
					s_tdata[12:7], want);
				expected_readouts.push_back(want);
			end
			outstanding <= expected_readouts.size();
		end
	end

endmodule

// File: bench/tb_board_sensor_serial_readout.sv
`timescale 1ns / 1ps

module tb_board_sensor_serial_readout;
	import bsr_pkg::*;
	import bsr_tb_pkg::*;

	localparam int CLK_PERIOD       = 8;
	localparam int QUIET_LIMIT      = 4000;  // cycles with no transaction on either side
	localparam int HOLD_CYCLES      = 300;   // long receiver hold-off
	localparam int DRAIN_CYCLES     = 80;    // covers a scan copy, plus margin
	localparam int RANDOM_PER_PHASE = 640;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // level[0], sensor_col[3:1], sensor_row[6:4], piece[12:7]
	logic [1:0]  s_tuser;   // kind[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // data_out[0], led_index[6:1], led_value[7]
	logic        m_tuser;   // led_write[0]

	int mismatches;
	int outstanding;

	// idle percentages per side; changed between phases
	int send_idle_pct = 24;
	int recv_idle_pct = 82;
	// bumped by the stimulus to ask the receiver for a long hold-off
	int hold_req      = 0;
	// transactions that the block acts on (unused kind not counted)
	int items_sent    = 0;

	board_sensor_serial_readout dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	bsr_readout_monitor monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Receiver: random back-pressure, or a counted hold-off when asked.
	initial begin : receiver
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: too long without any transaction means the block has hung.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// One input transaction. Valid stays high across back-to-back items; a
	// random gap drops it first. Returns just after the accepting edge.
	task automatic send_item(input item_kind_e kind, input logic level,
			input logic [2:0] col, input logic [2:0] row, input logic [5:0] piece);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {3'b000, piece, row, col, level};
		do @(posedge clk); while (!s_tready);
		if (kind != KIND_UNUSED)
			items_sent++;
	endtask

	// Line level change; the sensor fields carry junk, which must be ignored.
	task automatic set_line(input item_kind_e kind, input logic level);
		send_item(kind, level, 3'($urandom_range(7)), 3'($urandom_range(7)),
			6'($urandom_range(63)));
	endtask

	// Arm with A high across a falling B, then drop A: copies the board.
	task automatic scan_board();
		set_line(KIND_LINE_B, 1'b1);
		set_line(KIND_LINE_A, 1'b1);
		set_line(KIND_LINE_B, 1'b0);
		set_line(KIND_LINE_A, 1'b0);
	endtask

	// Mostly low ids so that matches turn up within a few hundred positions;
	// some empties and a few ids that can never match.
	function automatic logic [5:0] random_piece();
		int pick;
		pick = $urandom_range(99);
		if (pick < 20)
			return 6'd0;
		if (pick < 75)
			return 6'($urandom_range(1, 3));
		if (pick < 95)
			return 6'($urandom_range(1, BSR_NUM_IDS));
		return 6'($urandom_range(BSR_NUM_IDS + 1, 63));
	endfunction

	// Well-formed host sequence: a few sensor changes, a scan, then clocking
	// the position along with the odd LED write (B high or low).
	task automatic scan_and_read();
		int pulses;
		repeat ($urandom_range(6))
			send_item(KIND_SENSOR, 1'($urandom_range(1)), 3'($urandom_range(7)),
				3'($urandom_range(7)), random_piece());
		scan_board();
		pulses = ($urandom_range(9) < 7) ? $urandom_range(1, 40) : $urandom_range(60, 160);
		repeat (pulses) begin
			set_line(KIND_LINE_B, 1'b1);
			if ($urandom_range(19) == 0) begin
				set_line(KIND_LINE_A, 1'b1);
				set_line(KIND_LINE_A, 1'b0);
			end
			set_line(KIND_LINE_B, 1'b0);
			if ($urandom_range(19) == 0) begin
				set_line(KIND_LINE_A, 1'b1);
				set_line(KIND_LINE_A, 1'b0);
			end
		end
	endtask

	// Anything goes, unused kind included; may leave the lines in odd states.
	task automatic noise_burst();
		repeat ($urandom_range(1, 6))
			send_item(item_kind_e'($urandom_range(3)), 1'($urandom_range(1)),
				3'($urandom_range(7)), 3'($urandom_range(7)), 6'($urandom_range(63)));
	endtask

	// Sender stops until every expected readout has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int snd_pct, input int rcv_pct, input bit with_hold);
		int target;
		send_idle_pct <= snd_pct;
		recv_idle_pct <= rcv_pct;
		target = items_sent + RANDOM_PER_PHASE;
		if (with_hold) begin
			// receiver holds off while the sender keeps offering: input stalls
			hold_req <= hold_req + 1;
			scan_and_read();
		end
		while (items_sent < target) begin
			if ($urandom_range(9) < 7)
				scan_and_read();
			else
				noise_burst();
		end
		drain();
	endtask

	initial begin : stimulus
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= KIND_LINE_A;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, id 1 placed where square 0 reads it,
		// an id above the range, unused kind, unchanged levels, LED writes
		// with B low and high, and scans with and without a match.
		send_item(KIND_SENSOR, 1'b0, 3'd7, 3'd7, 6'd1);
		send_item(KIND_SENSOR, 1'b1, 3'd7, 3'd6, 6'd2);
		send_item(KIND_SENSOR, 1'b0, 3'd0, 3'd0, 6'd63);
		send_item(KIND_SENSOR, 1'b1, 3'd3, 3'd4, 6'(BSR_NUM_IDS));
		send_item(KIND_UNUSED, 1'b1, 3'd5, 3'd2, 6'd17);
		set_line(KIND_LINE_A, 1'b0);          // level unchanged
		set_line(KIND_LINE_B, 1'b1);
		set_line(KIND_LINE_B, 1'b1);          // level unchanged
		set_line(KIND_LINE_B, 1'b0);          // position 1
		set_line(KIND_LINE_A, 1'b1);
		set_line(KIND_LINE_A, 1'b0);          // LED 1 <- 0
		set_line(KIND_LINE_B, 1'b1);
		set_line(KIND_LINE_A, 1'b1);
		set_line(KIND_LINE_A, 1'b0);          // LED 1 <- 1
		set_line(KIND_LINE_A, 1'b1);
		set_line(KIND_LINE_B, 1'b0);          // armed, position 2
		set_line(KIND_LINE_A, 1'b0);          // scan, square 0 holds id 1
		set_line(KIND_LINE_B, 1'b1);
		set_line(KIND_LINE_B, 1'b0);          // square 1, id 2 does not match yet
		send_item(KIND_SENSOR, 1'b0, 3'd7, 3'd7, 6'd0);
		scan_board();                         // square 0 now empty
		send_item(KIND_UNUSED, 1'b1, 3'd7, 3'd7, 6'd63);
		drain();

		// Random: sender idles 24 / receiver 82, then swapped, then neither.
		run_phase(24, 82, 1'b0);
		run_phase(82, 24, 1'b1);
		run_phase(0, 0, 1'b1);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
